/* rtl/cellsr_pkg.sv */
// shared constants, types and helpers for the cell sensitivity rules block
`timescale 1ns / 1ps
`default_nettype none

package cellsr_pkg;

   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int MAX_TOP_N  = 15;

   localparam int TOTAL_BITS = (VALUE_BITS + COUNT_BITS > 64) ? 64 : VALUE_BITS + COUNT_BITS;
   localparam int TOPN_BITS  = $clog2(MAX_TOP_N + 1);
   localparam int TOP_BITS   = VALUE_BITS + TOPN_BITS;
   localparam int PROD_BITS  = ((TOTAL_BITS > TOP_BITS) ? TOTAL_BITS : TOP_BITS) + 8;

   localparam int CONTRIB_W    = 32;
   localparam int CELL_COUNT_W = 16;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam int MID_DEPTH    = 4;
   localparam int MID_PTR_BITS = $clog2(MID_DEPTH);

   localparam int OQ_DEPTH     = 2;
   localparam int OQ_PTR_BITS  = $clog2(OQ_DEPTH);

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CONTRIB = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_P_PERCENT   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOM_N       = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOM_K       = 2'd3;

   localparam logic [1:0] RULE_NONE = 2'd0;
   localparam logic [1:0] RULE_FEW  = 2'd1;
   localparam logic [1:0] RULE_PPCT = 2'd2;
   localparam logic [1:0] RULE_DOM  = 2'd3;

   localparam logic [15:0] MIN_CONTRIB_RESET = 16'd2;

   typedef struct packed {
      logic [15:0] min_contrib;
      logic [7:0]  p_percent;
      logic [3:0]  dom_n;
      logic [6:0]  dom_k;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [TOTAL_BITS-1:0] total;
      logic [VALUE_BITS-1:0] x1;
      logic [VALUE_BITS-1:0] x2;
      logic [TOP_BITS-1:0]   top;
   } cell_sum_type;

   typedef struct packed {
      logic                    sensitive;
      logic [1:0]              rule_hit;
      logic [CELL_COUNT_W-1:0] cell_count;
   } rsp_type;

   function automatic logic [VALUE_BITS-1:0] value_from_field(input logic [CONTRIB_W-1:0] f);
      logic [63:0] t;
      t = 64'(f);
      return t[VALUE_BITS-1:0];
   endfunction

   function automatic logic [CELL_COUNT_W-1:0] count_to_field(input logic [COUNT_BITS-1:0] c);
      logic [31:0] t;
      t = 32'(c);
      return t[CELL_COUNT_W-1:0];
   endfunction

   function automatic logic [PROD_BITS-1:0] times_hundred(input logic [PROD_BITS-1:0] x);
      return (x << 6) + (x << 5) + (x << 2);
   endfunction

endpackage

`default_nettype wire

/* rtl/cellsr_front.sv */
// front end: accepts contributions and accumulates the per-cell summary
`timescale 1ns / 1ps
`default_nettype none

module cellsr_front
   import cellsr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cfg_type              cfg,
   input  wire logic                 req_push,
   input  wire logic [CONTRIB_W-1:0] req_contribution,
   input  wire logic                 req_last_of_cell,
   output logic                      req_full,
   input  wire logic                 sum_full,
   output logic                      sum_push,
   output cell_sum_type              sum_data
);

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [VALUE_BITS-1:0] x1_ff, x1_in;
   logic [VALUE_BITS-1:0] x2_ff, x2_in;
   logic [TOP_BITS-1:0]   top_ff, top_in;

   logic [VALUE_BITS-1:0] v;
   logic [TOPN_BITS-1:0]  n_eff;
   logic                  in_top;
   logic [TOTAL_BITS:0]   total_sum;
   logic                  accept;

   always_comb begin
      v         = value_from_field(req_contribution);
      n_eff     = (32'(cfg.dom_n) > MAX_TOP_N) ? TOPN_BITS'(MAX_TOP_N) : TOPN_BITS'(cfg.dom_n);
      in_top    = 32'(count_ff) < 32'(n_eff);
      total_sum = {1'b0, total_ff} + (TOTAL_BITS + 1)'(v);
      total_in  = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
      count_in  = (count_ff == '1) ? count_ff : count_ff + 1'b1;
      x1_in     = (count_ff == '0) ? v : x1_ff;
      x2_in     = (count_ff == COUNT_BITS'(1)) ? v : x2_ff;
      top_in    = in_top ? top_ff + TOP_BITS'(v) : top_ff;
      accept    = req_push & ~sum_full;
      req_full  = sum_full;
      sum_push  = accept & req_last_of_cell;
      sum_data.count = count_in;
      sum_data.total = total_in;
      sum_data.x1    = x1_in;
      sum_data.x2    = x2_in;
      sum_data.top   = top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         x1_ff    <= '0;
         x2_ff    <= '0;
         top_ff   <= '0;
      end else if (accept) begin
         if (req_last_of_cell) begin
            count_ff <= '0;
            total_ff <= '0;
            x1_ff    <= '0;
            x2_ff    <= '0;
            top_ff   <= '0;
         end else begin
            count_ff <= count_in;
            total_ff <= total_in;
            x1_ff    <= x1_in;
            x2_ff    <= x2_in;
            top_ff   <= top_in;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/cellsr_fifo.sv */
// short queue of cell summaries between the front and back ends
`timescale 1ns / 1ps
`default_nettype none

module cellsr_fifo
   import cellsr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire cell_sum_type din,
   output logic              full,
   input  wire logic         pop,
   output cell_sum_type      dout,
   output logic              empty
);

   cell_sum_type              mem_ff [MID_DEPTH];
   logic [MID_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [MID_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [MID_PTR_BITS:0]     cnt_ff, cnt_in;
   logic                      do_push, do_pop;

   always_comb begin
      full      = cnt_ff == (MID_PTR_BITS + 1)'(MID_DEPTH);
      empty     = cnt_ff == '0;
      do_push   = push & ~full;
      do_pop    = pop & ~empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (MID_PTR_BITS + 1)'(do_push) - (MID_PTR_BITS + 1)'(do_pop);
      dout      = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/cellsr_back.sv */
// back end: rule evaluation pipeline and result queue
`timescale 1ns / 1ps
`default_nettype none

module cellsr_back
   import cellsr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cfg_type                 cfg,
   input  wire logic                    sum_valid,
   input  wire cell_sum_type            sum_data,
   output logic                         sum_pop,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic                         rsp_sensitive,
   output logic [1:0]                   rsp_rule_hit,
   output logic [CELL_COUNT_W-1:0]      rsp_cell_count
);

   // stage a: remainder and too-few check
   logic                  a_valid_ff;
   logic                  a_few_ff, a_few_in;
   logic                  a_pnz_ff, a_nnz_ff;
   logic [TOTAL_BITS-1:0] a_rem_ff, a_rem_in;
   logic [TOTAL_BITS-1:0] a_total_ff;
   logic [VALUE_BITS-1:0] a_x1_ff;
   logic [TOP_BITS-1:0]   a_top_ff;
   logic [COUNT_BITS-1:0] a_count_ff;
   logic [VALUE_BITS:0]   x12;

   // stage b: products
   logic                  b_valid_ff;
   logic                  b_few_ff, b_pnz_ff, b_nnz_ff;
   logic [COUNT_BITS-1:0] b_count_ff;
   logic [PROD_BITS-1:0]  b_prod_a_ff, b_prod_b_ff, b_prod_c_ff, b_prod_d_ff;

   // result queue
   rsp_type               oq_ff [OQ_DEPTH];
   logic [OQ_PTR_BITS-1:0] oq_wr_ff, oq_rd_ff;
   logic [OQ_PTR_BITS:0]   oq_cnt_ff, oq_cnt_in;
   logic                  oq_space, oq_pop;
   rsp_type               rsp_in;
   logic [1:0]            rule;

   logic                  b_go, b_take, a_go, a_take;

   always_comb begin
      oq_space = oq_cnt_ff != (OQ_PTR_BITS + 1)'(OQ_DEPTH);
      b_go     = b_valid_ff & oq_space;
      b_take   = ~b_valid_ff | b_go;
      a_go     = a_valid_ff & b_take;
      a_take   = ~a_valid_ff | a_go;
      sum_pop  = sum_valid & a_take;

      x12      = (VALUE_BITS + 1)'(sum_data.x1) + (VALUE_BITS + 1)'(sum_data.x2);
      a_rem_in = (sum_data.total >= TOTAL_BITS'(x12)) ?
                 sum_data.total - TOTAL_BITS'(x12) : '0;
      a_few_in = 32'(sum_data.count) <= 32'(cfg.min_contrib);

      priority if (b_few_ff) begin
         rule = RULE_FEW;
      end else if (b_pnz_ff && (b_prod_a_ff < b_prod_b_ff)) begin
         rule = RULE_PPCT;
      end else if (b_nnz_ff && (b_prod_c_ff < b_prod_d_ff)) begin
         rule = RULE_DOM;
      end else begin
         rule = RULE_NONE;
      end
      rsp_in.sensitive  = rule != RULE_NONE;
      rsp_in.rule_hit   = rule;
      rsp_in.cell_count = count_to_field(b_count_ff);

      oq_pop    = rsp_pop & (oq_cnt_ff != '0);
      oq_cnt_in = oq_cnt_ff + (OQ_PTR_BITS + 1)'(b_go) - (OQ_PTR_BITS + 1)'(oq_pop);

      rsp_empty      = oq_cnt_ff == '0;
      rsp_sensitive  = oq_ff[oq_rd_ff].sensitive;
      rsp_rule_hit   = oq_ff[oq_rd_ff].rule_hit;
      rsp_cell_count = oq_ff[oq_rd_ff].cell_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         oq_wr_ff   <= '0;
         oq_rd_ff   <= '0;
         oq_cnt_ff  <= '0;
      end else begin
         if (a_take) begin
            a_valid_ff <= sum_valid;
         end
         if (b_take) begin
            b_valid_ff <= a_valid_ff;
         end
         if (b_go) begin
            oq_wr_ff <= oq_wr_ff + 1'b1;
         end
         if (oq_pop) begin
            oq_rd_ff <= oq_rd_ff + 1'b1;
         end
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_pop) begin
         a_few_ff   <= a_few_in;
         a_pnz_ff   <= cfg.p_percent != '0;
         a_nnz_ff   <= cfg.dom_n != '0;
         a_rem_ff   <= a_rem_in;
         a_total_ff <= sum_data.total;
         a_x1_ff    <= sum_data.x1;
         a_top_ff   <= sum_data.top;
         a_count_ff <= sum_data.count;
      end
      if (a_go) begin
         b_few_ff    <= a_few_ff;
         b_pnz_ff    <= a_pnz_ff;
         b_nnz_ff    <= a_nnz_ff;
         b_count_ff  <= a_count_ff;
         b_prod_a_ff <= times_hundred(PROD_BITS'(a_rem_ff));
         b_prod_b_ff <= PROD_BITS'(a_x1_ff) * PROD_BITS'(cfg.p_percent);
         b_prod_c_ff <= PROD_BITS'(a_total_ff) * PROD_BITS'(cfg.dom_k);
         b_prod_d_ff <= times_hundred(PROD_BITS'(a_top_ff));
      end
      if (b_go) begin
         oq_ff[oq_wr_ff] <= rsp_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/cell_sensitivity_rules.sv */
// top level of the cell sensitivity rules block
// Usage:
//  Input queue: push one contribution per transfer (push high, full low),
//  largest value first, with last_of_cell set on the final value of a cell.
//  Result queue: one verdict per cell; the oldest verdict sits on the rsp_
//  ports while empty is low and leaves on a transfer with pop high.
//  Configuration: csr_we writes csr_wdata into register csr_index
//  (min contributors, p percent, dominance n, dominance k); write only
//  while no cell is in progress and no verdict is outstanding.
//  Throughput: one contribution per cycle while full is low, set by the
//  accumulator in the front end; cells of a single contribution also sustain
//  one verdict per cycle through the back-end pipeline while pop is held high.
//  Path: a verdict passes from the transfer of the last contribution of
//  its cell through the summary queue, the remainder stage, the product
//  stage and then the result queue before it is visible.
//  Stalls: when pop stays low the two-entry result queue fills, the rule
//  pipeline holds, the four-entry summary queue fills and full then rises;
//  open cells keep their partial sums while stalled.
//  Reset: synchronous; clears partial sums, all queues and the pipeline and
//  sets the registers to min contributors 2 and the others 0.
`timescale 1ns / 1ps
`default_nettype none

module cell_sensitivity_rules
   import cellsr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_push,
   output logic                         req_full,
   input  wire logic [CONTRIB_W-1:0]    req_contribution,
   input  wire logic                    req_last_of_cell,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output logic                         rsp_sensitive,
   output logic [1:0]                   rsp_rule_hit,
   output logic [CELL_COUNT_W-1:0]      rsp_cell_count,
   input  wire logic                    csr_we,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type      cfg_ff;
   cell_sum_type front_sum, mid_sum;
   logic         front_push, mid_full, mid_empty, mid_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_contrib <= MIN_CONTRIB_RESET;
         cfg_ff.p_percent   <= '0;
         cfg_ff.dom_n       <= '0;
         cfg_ff.dom_k       <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_CONTRIB: cfg_ff.min_contrib <= csr_wdata;
            CSR_P_PERCENT:   cfg_ff.p_percent   <= csr_wdata[7:0];
            CSR_DOM_N:       cfg_ff.dom_n       <= csr_wdata[3:0];
            CSR_DOM_K:       cfg_ff.dom_k       <= csr_wdata[6:0];
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   cellsr_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .req_push         (req_push),
      .req_contribution (req_contribution),
      .req_last_of_cell (req_last_of_cell),
      .req_full         (req_full),
      .sum_full         (mid_full),
      .sum_push         (front_push),
      .sum_data         (front_sum)
   );

   cellsr_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .din   (front_sum),
      .full  (mid_full),
      .pop   (mid_pop),
      .dout  (mid_sum),
      .empty (mid_empty)
   );

   cellsr_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .sum_valid      (~mid_empty),
      .sum_data       (mid_sum),
      .sum_pop        (mid_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_sensitive  (rsp_sensitive),
      .rsp_rule_hit   (rsp_rule_hit),
      .rsp_cell_count (rsp_cell_count)
   );

endmodule

`default_nettype wire

/* rtl/cellsr_checker.sv */
// port-level assertions for the cell sensitivity rules block, with its bind
`timescale 1ns / 1ps
`default_nettype none

module cellsr_checker
   import cellsr_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    rsp_empty,
   input  wire logic                    rsp_pop,
   input  wire logic                    rsp_sensitive,
   input  wire logic [1:0]              rsp_rule_hit,
   input  wire logic [CELL_COUNT_W-1:0] rsp_cell_count
);

   // no verdict right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // verdict flag agrees with the rule code
   a_flag_rule: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_sensitive == (rsp_rule_hit != RULE_NONE)))
      else $error("sensitive flag disagrees with rule code");

   // every verdict covers at least one contribution
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_cell_count != '0))
      else $error("verdict with zero contributions");

   // a waiting verdict holds until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_rule_hit) && $stable(rsp_cell_count)))
      else $error("waiting verdict changed or vanished");

endmodule

bind cell_sensitivity_rules cellsr_checker u_cellsr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_sensitive  (rsp_sensitive),
   .rsp_rule_hit   (rsp_rule_hit),
   .rsp_cell_count (rsp_cell_count)
);

`default_nettype wire

/* bench/verdict_checker.sv */
// checker module: predicts the verdict of each cell and compares it with the result queue
`timescale 1ns / 1ps

module verdict_checker
   import cellsr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  logic                    req_full,
   input  logic [CONTRIB_W-1:0]    req_contribution,
   input  logic                    req_last_of_cell,
   input  logic                    rsp_empty,
   input  logic                    rsp_pop,
   input  logic                    rsp_sensitive,
   input  logic [1:0]              rsp_rule_hit,
   input  logic [CELL_COUNT_W-1:0] rsp_cell_count,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output int                      errors,
   output int                      pending,
   output int                      verdicts,
   output int                      flagged
);

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   cfg_type               cfg;
   logic [TOTAL_BITS-1:0] acc_total;
   logic [COUNT_BITS-1:0] acc_count;
   logic [VALUE_BITS-1:0] lead_value;
   logic [VALUE_BITS-1:0] runner_value;
   logic [TOP_BITS-1:0]   head_sum;
   rsp_type               expected_verdicts[$];

   task automatic clear_cell();
      acc_total    = '0;
      acc_count    = '0;
      lead_value   = '0;
      runner_value = '0;
      head_sum     = '0;
   endtask

   task automatic fold_contribution(input logic [CONTRIB_W-1:0] field, input logic last);
      logic [VALUE_BITS-1:0] v;
      logic [TOTAL_BITS:0]   sum;
      logic [VALUE_BITS:0]   pair;
      logic [TOTAL_BITS-1:0] rest;
      logic [5:0]            reach;
      logic [1:0]            rule;
      rsp_type               verdict;
      v = field[VALUE_BITS-1:0];
      reach = (cfg.dom_n > MAX_TOP_N) ? MAX_TOP_N : cfg.dom_n;
      if (acc_count == 0) begin
         lead_value = v;
      end else if (acc_count == 1) begin
         runner_value = v;
      end
      if (acc_count < reach) begin
         head_sum = head_sum + v;
      end
      sum = acc_total + v;
      acc_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
      if (acc_count != COUNT_MAX) begin
         acc_count = acc_count + 1'b1;
      end
      if (last) begin
         pair = lead_value + runner_value;
         rest = (acc_total >= pair) ? acc_total - pair : '0;
         if (acc_count <= cfg.min_contrib) begin
            rule = RULE_FEW;
         end else if (cfg.p_percent != 0 &&
                      64'(rest) * 64'd100 < 64'(cfg.p_percent) * 64'(lead_value)) begin
            rule = RULE_PPCT;
         end else if (reach != 0 &&
                      64'(cfg.dom_k) * 64'(acc_total) < 64'd100 * 64'(head_sum)) begin
            rule = RULE_DOM;
         end else begin
            rule = RULE_NONE;
         end
         verdict.sensitive  = (rule != RULE_NONE);
         verdict.rule_hit   = rule;
         verdict.cell_count = CELL_COUNT_W'(acc_count);
         expected_verdicts.push_back(verdict);
         clear_cell();
      end
   endtask

   task automatic check_verdict();
      rsp_type want;
      if (expected_verdicts.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("checker: unpredicted verdict sens=%0b rule=%0d count=%0d",
                     rsp_sensitive, rsp_rule_hit, rsp_cell_count);
         end
      end else begin
         want = expected_verdicts.pop_front();
         verdicts++;
         if (rsp_sensitive) begin
            flagged++;
         end
         if (want.sensitive !== rsp_sensitive || want.rule_hit !== rsp_rule_hit ||
             want.cell_count !== rsp_cell_count) begin
            errors++;
            if (errors <= 10) begin
               $display("checker: verdict %0d expected sens=%0b rule=%0d count=%0d, got sens=%0b rule=%0d count=%0d",
                        verdicts, want.sensitive, want.rule_hit, want.cell_count,
                        rsp_sensitive, rsp_rule_hit, rsp_cell_count);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg.min_contrib = MIN_CONTRIB_RESET;
         cfg.p_percent   = '0;
         cfg.dom_n       = '0;
         cfg.dom_k       = '0;
         clear_cell();
         expected_verdicts.delete();
         errors   = 0;
         verdicts = 0;
         flagged  = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_verdict();
         end
         if (req_push && !req_full) begin
            fold_contribution(req_contribution, req_last_of_cell);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MIN_CONTRIB: cfg.min_contrib = csr_wdata;
               CSR_P_PERCENT:   cfg.p_percent   = csr_wdata[7:0];
               CSR_DOM_N:       cfg.dom_n       = csr_wdata[3:0];
               CSR_DOM_K:       cfg.dom_k       = csr_wdata[6:0];
               default: ;
            endcase
         end
      end
      pending = expected_verdicts.size();
   end

endmodule

/* bench/tb.sv */
// testbench top: drives cells of contributions and register settings, gives the verdict
`timescale 1ns / 1ps

module tb;
   import cellsr_pkg::*;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_push         = 1'b0;
   logic                    req_full;
   logic [CONTRIB_W-1:0]    req_contribution = '0;
   logic                    req_last_of_cell = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop          = 1'b0;
   logic                    rsp_sensitive;
   logic [1:0]              rsp_rule_hit;
   logic [CELL_COUNT_W-1:0] rsp_cell_count;
   logic                    csr_we           = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata        = '0;

   int          errors;
   int          pending;
   int          verdicts;
   int          flagged;
   int unsigned push_idle   = 0;
   int unsigned pop_idle    = 0;
   int unsigned sent_values = 0;
   int unsigned sent_cells  = 0;
   cfg_type     settings[6];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   cell_sensitivity_rules dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_contribution (req_contribution),
      .req_last_of_cell (req_last_of_cell),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sensitive    (rsp_sensitive),
      .rsp_rule_hit     (rsp_rule_hit),
      .rsp_cell_count   (rsp_cell_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   verdict_checker u_verdicts (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_contribution (req_contribution),
      .req_last_of_cell (req_last_of_cell),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_sensitive    (rsp_sensitive),
      .rsp_rule_hit     (rsp_rule_hit),
      .rsp_cell_count   (rsp_cell_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .errors           (errors),
      .pending          (pending),
      .verdicts         (verdicts),
      .flagged          (flagged)
   );

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_idle);
   end

   task automatic push_value(input logic [CONTRIB_W-1:0] value, input logic last);
      while ($urandom_range(99) < push_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_contribution <= value;
      req_last_of_cell <= last;
      do @(posedge clock); while (req_full);
      sent_values++;
      if (last) begin
         sent_cells++;
      end
   endtask

   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_CONTRIB;
      csr_wdata <= c.min_contrib;
      @(posedge clock);
      csr_index <= CSR_P_PERCENT;
      csr_wdata <= CSR_DATA_W'(c.p_percent);
      @(posedge clock);
      csr_index <= CSR_DOM_N;
      csr_wdata <= CSR_DATA_W'(c.dom_n);
      @(posedge clock);
      csr_index <= CSR_DOM_K;
      csr_wdata <= CSR_DATA_W'(c.dom_k);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [CONTRIB_W-1:0] lead_draw();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(1000);
         2: return '1;
         3: return $urandom >> $urandom_range(31);
         4: return '0;
         default: return $urandom_range(32'hFFFF_FFFF, 32'hF000_0000);
      endcase
   endfunction

   function automatic logic [CONTRIB_W-1:0] next_draw(input logic [CONTRIB_W-1:0] prev);
      case ($urandom_range(9))
         0: return $urandom;
         1, 2: return prev;
         3, 4, 5: return $urandom_range(prev);
         6, 7: return prev >> $urandom_range(4, 1);
         default: return prev - (prev >> 4);
      endcase
   endfunction

   task automatic send_cell();
      int unsigned          size;
      logic [CONTRIB_W-1:0] value;
      case ($urandom_range(19))
         0: size = $urandom_range(40, 21);
         1, 2, 3, 4, 5: size = $urandom_range(20, 7);
         default: size = $urandom_range(6, 1);
      endcase
      value = lead_draw();
      for (int unsigned i = 1; i <= size; i++) begin
         push_value(value, i == size);
         value = next_draw(value);
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int unsigned target;
      // min contributors, p percent, dominance n, dominance k
      settings[0] = {16'd0,  8'd255, 4'd15, 7'd100};
      settings[1] = {16'd1,  8'd10,  4'd1,  7'd50};
      settings[2] = {16'd3,  8'd0,   4'd4,  7'd0};
      settings[3] = {16'd0,  8'd1,   4'd2,  7'd99};
      settings[4] = {16'd5,  8'd100, 4'd3,  7'd90};
      settings[5] = {16'd2,  8'd200, 4'd8,  7'd30};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_idle = 34;
      pop_idle  = 77;
      apply_settings({16'd2, 8'd50, 4'd2, 7'd70});
      // lone zero and lone maximum
      push_value('0, 1'b1);
      push_value('1, 1'b1);
      // p-percent rule
      push_value(32'd100, 1'b0);
      push_value(32'd1, 1'b0);
      push_value(32'd1, 1'b1);
      // no rule fires
      repeat (3) push_value(32'd10, 1'b0);
      push_value(32'd10, 1'b1);
      // dominance rule
      push_value(32'd40, 1'b0);
      push_value(32'd40, 1'b0);
      push_value(32'd10, 1'b0);
      push_value(32'd10, 1'b0);
      push_value(32'd10, 1'b1);
      // ascending values
      push_value(32'd1, 1'b0);
      push_value(32'd2, 1'b0);
      push_value(32'd3, 1'b0);
      push_value(32'd1000, 1'b1);
      // zero total
      repeat (3) push_value('0, 1'b0);
      push_value('0, 1'b1);
      // all maximum
      repeat (2) push_value('1, 1'b0);
      push_value('1, 1'b1);
      drain();

      for (int s = 0; s < 6; s++) begin
         push_idle = (s < 2) ? 34 : (s < 4) ? 77 : 0;
         pop_idle  = (s < 2) ? 77 : (s < 4) ? 34 : 0;
         apply_settings(settings[s]);
         target = sent_values + 125;
         while (sent_values < target) send_cell();
         drain();
      end

      $display("tb: %0d contributions in %0d cells over 7 register settings and 3 idle patterns",
               sent_values, sent_cells);
      $display("tb: %0d verdicts checked, %0d sensitive, %0d mismatches",
               verdicts, flagged, errors);
      if (errors == 0 && pending == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
